/* rtl/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned START_W     = 32;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned PAT_W       = 64;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 5;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_WILDCARD_MASK  = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } reg_index_t;

endpackage

/* rtl/wbps_in_if.sv */
// Input channel interface carrying one buffer byte per transfer.
interface wbps_in_if;
  logic                           valid;
  logic                           ready;
  logic [wbps_pkg::BYTE_W-1:0]    data_byte;
  logic                           last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/wbps_out_if.sv */
// Result channel interface carrying one scan result per transfer.
interface wbps_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [wbps_pkg::START_W-1:0]   match_start;
  logic [wbps_pkg::COUNT_W-1:0]   match_total;
  logic                           buffer_end;

  modport source (output valid, output hit, output match_start, output match_total,
                  output buffer_end, input ready);
  modport sink (input valid, input hit, input match_start, input match_total,
                input buffer_end, output ready);
endinterface

/* rtl/wildcard_byte_pattern_scan_core.sv */
// Top level of the wildcard byte pattern scanner with its configuration registers.
// A transferred byte passes through the input register and then the result register.
// Throughput: one byte per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (rst_n low, synchronous) clears the configuration registers, the window
// fill, the position and match counters and both valid flags.
module wildcard_byte_pattern_scan_core #(
  parameter int unsigned PATTERN_MAX   = 8,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wbps_in_if.sink                             in_ch,
  wbps_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned DIFF_W = (POSITION_BITS > wbps_pkg::START_W) ?
                                   POSITION_BITS : wbps_pkg::START_W;

  logic [wbps_pkg::PAT_W-1:0]   pattern_r;
  logic [wbps_pkg::MASK_W-1:0]  wild_r;
  logic [wbps_pkg::LEN_W-1:0]   len_r;
  wbps_pkg::reg_index_t         reg_idx;
  logic                         cfg_wr;

  logic                         s1_valid_r;
  logic [wbps_pkg::BYTE_W-1:0]  s1_data_r;
  logic                         s1_last_r;

  logic [wbps_pkg::BYTE_W-1:0]  win_r   [PATTERN_MAX];
  logic [wbps_pkg::BYTE_W-1:0]  win_nxt [PATTERN_MAX];
  logic [FILL_W-1:0]            fill_r;
  logic [FILL_W-1:0]            fill_nxt;
  logic [POSITION_BITS-1:0]     pos_r;
  logic [POSITION_BITS-1:0]     pos_nxt;
  logic [wbps_pkg::COUNT_W-1:0] count_r;
  logic [wbps_pkg::COUNT_W-1:0] count_nxt;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [wbps_pkg::START_W-1:0] out_start_r;
  logic [wbps_pkg::COUNT_W-1:0] out_total_r;
  logic                         out_end_r;

  logic                         advance;
  logic                         step;
  logic [PATTERN_MAX-1:0]       len_match;
  logic [PATTERN_MAX-1:0]       len_sel;
  logic                         hit;
  logic [DIFF_W-1:0]            start_diff;
  logic [wbps_pkg::START_W-1:0] start_nxt;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_idx = wbps_pkg::reg_index_t'(paddr[wbps_pkg::CFG_ADDR_W-1:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (reg_idx)
      wbps_pkg::REG_PATTERN_BYTES:  prdata = pattern_r;
      wbps_pkg::REG_WILDCARD_MASK:  prdata = wbps_pkg::CFG_DATA_W'(wild_r);
      wbps_pkg::REG_PATTERN_LENGTH: prdata = wbps_pkg::CFG_DATA_W'(len_r);
      default:                      prdata = '0;
    endcase
  end

  // Pipeline control.
  assign advance      = ~out_valid_r | out_ch.ready;
  assign in_ch.ready  = advance | ~s1_valid_r;
  assign step         = s1_valid_r & advance;

  // Window after shifting in the current byte, newest first.
  assign win_nxt[0] = s1_data_r;
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_shift
    assign win_nxt[k] = win_r[k-1];
  end

  assign fill_nxt = (fill_r == FILL_W'(PATTERN_MAX)) ? fill_r : fill_r + 1'b1;

  // One comparator row per possible pattern length.
  for (genvar gl = 1; gl <= PATTERN_MAX; gl++) begin : g_len
    logic [PATTERN_MAX-1:0] byte_ok;
    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_byte
      if (gi < gl) begin : g_used
        assign byte_ok[gi] = wild_r[gi] |
                             (pattern_r[wbps_pkg::BYTE_W*gi +: wbps_pkg::BYTE_W] ==
                              win_nxt[gl-1-gi]);
      end else begin : g_unused
        assign byte_ok[gi] = 1'b1;
      end
    end
    assign len_match[gl-1] = &byte_ok;
    assign len_sel[gl-1]   = (len_r == wbps_pkg::LEN_W'(gl));
  end

  assign hit = (|(len_match & len_sel)) &
               (wbps_pkg::LEN_W'(fill_nxt) >= len_r);

  assign start_diff = DIFF_W'(pos_r) - DIFF_W'(len_r - 1'b1);
  assign start_nxt  = hit ? start_diff[wbps_pkg::START_W-1:0] : '0;
  assign pos_nxt    = (pos_r == '1) ? pos_r : pos_r + 1'b1;
  assign count_nxt  = (hit && (count_r != '1)) ? count_r + 1'b1 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      wild_r      <= '0;
      len_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      pos_r       <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          wbps_pkg::REG_PATTERN_BYTES:  pattern_r <= pwdata;
          wbps_pkg::REG_WILDCARD_MASK:  wild_r    <= pwdata[wbps_pkg::MASK_W-1:0];
          wbps_pkg::REG_PATTERN_LENGTH: len_r     <= pwdata[wbps_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        if (s1_last_r) begin
          fill_r  <= '0;
          pos_r   <= '0;
          count_r <= '0;
        end else begin
          fill_r  <= fill_nxt;
          pos_r   <= pos_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_data_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
    if (step) begin
      win_r       <= win_nxt;
      out_hit_r   <= hit;
      out_start_r <= start_nxt;
      out_total_r <= count_nxt;
      out_end_r   <= s1_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.match_start = out_start_r;
  assign out_ch.match_total = out_total_r;
  assign out_ch.buffer_end  = out_end_r;

endmodule

/* rtl/wbps_checker.sv */
// Port-level checker for the scanner core and the bind that attaches it.
module wbps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_hit,
  input logic [wbps_pkg::START_W-1:0]   out_match_start,
  input logic [wbps_pkg::COUNT_W-1:0]   out_match_total,
  input logic                           out_buffer_end
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_hit) && $stable(out_match_start) &&
      $stable(out_match_total) && $stable(out_buffer_end))
    else $error("stalled result changed");

  // A result without a hit reports a zero start offset.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_match_start == '0)
    else $error("start offset set without a hit");

  // A hit is always counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_match_total != '0)
    else $error("hit with zero match total");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_match_start (out_ch.match_start),
  .out_match_total (out_ch.match_total),
  .out_buffer_end  (out_ch.buffer_end)
);

/* tb/tb.sv */
// Self-checking testbench for the wildcard byte pattern scan core, with its own scan predictor.
module tb;

  localparam int unsigned SCAN_DEPTH   = 8;
  localparam int unsigned RANDOM_BYTES = 1100;
  localparam logic [1:0]  REG_UNMAPPED = 2'd3;

  typedef struct {
    bit                           hit;
    bit [wbps_pkg::START_W-1:0]   start;
    bit [wbps_pkg::COUNT_W-1:0]   total;
    bit                           buf_end;
  } scan_result_t;

  class scan_scoreboard;
    bit [wbps_pkg::PAT_W-1:0]     pattern;
    bit [wbps_pkg::MASK_W-1:0]    wild;
    bit [wbps_pkg::LEN_W-1:0]     pat_len;
    bit [wbps_pkg::BYTE_W-1:0]    window [SCAN_DEPTH];
    int unsigned                  fill;
    bit [31:0]                    position;
    bit [wbps_pkg::COUNT_W-1:0]   hit_count;
    scan_result_t                 expected_q [$];
    int unsigned                  errors;
    int unsigned                  bytes_seen;
    int unsigned                  results_seen;
    int unsigned                  hits_seen;
    int unsigned                  buffers_seen;

    function new();
      pattern = '0;
      wild = '0;
      pat_len = '0;
      errors = 0;
      bytes_seen = 0;
      results_seen = 0;
      hits_seen = 0;
      buffers_seen = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (window[i]) window[i] = '0;
      fill = 0;
      position = '0;
      hit_count = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [wbps_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        wbps_pkg::REG_PATTERN_BYTES: begin
          pattern = value[wbps_pkg::PAT_W-1:0];
        end
        wbps_pkg::REG_WILDCARD_MASK: begin
          wild = value[wbps_pkg::MASK_W-1:0];
        end
        wbps_pkg::REG_PATTERN_LENGTH: begin
          pat_len = value[wbps_pkg::LEN_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function bit window_hit();
      int unsigned n;
      n = pat_len;
      if (n == 0 || n > SCAN_DEPTH || fill < n) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!wild[i] && pattern[8*i +: 8] != window[n-1-i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [wbps_pkg::BYTE_W-1:0] data, logic last);
      scan_result_t r;
      for (int i = SCAN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      if (fill < SCAN_DEPTH) fill++;
      r.hit = window_hit();
      r.start = '0;
      if (r.hit) begin
        r.start = position - (32'(pat_len) - 32'd1);
        if (hit_count != '1) hit_count++;
      end
      r.total = hit_count;
      r.buf_end = last;
      expected_q.insert(expected_q.size(), r);
      bytes_seen++;
      if (position != '1) position++;
      if (last) clear_scan();
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
    endfunction

    function void check_result(logic hit, logic [wbps_pkg::START_W-1:0] start,
                               logic [wbps_pkg::COUNT_W-1:0] total, logic buf_end);
      scan_result_t e;
      results_seen++;
      if (hit === 1'b1) hits_seen++;
      if (buf_end === 1'b1) buffers_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result transfer %0d arrived with no byte outstanding", results_seen));
        return;
      end
      e = expected_q.pop_front();
      if (e.hit !== hit || e.start !== start || e.total !== total || e.buf_end !== buf_end) begin
        report($sformatf({"result %0d: expected hit=%0b start=%0d total=%0d end=%0b, ",
                          "got hit=%0b start=%0d total=%0d end=%0b"}, results_seen,
                         e.hit, e.start, e.total, e.buf_end, hit, start, total, buf_end));
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [wbps_pkg::CFG_ADDR_W-1:0]  paddr;
  logic [wbps_pkg::CFG_DATA_W-1:0]  pwdata;
  logic [wbps_pkg::CFG_DATA_W-1:0]  prdata;
  logic                             pready;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_scan_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scan_scoreboard sb = new();
  bit             no_stalls = 1'b0;
  int unsigned    buf_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.hit, out_ch.match_start, out_ch.match_total, out_ch.buffer_end);
      end
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.last_byte);
    end
  end

  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = no_stalls ? 0 : pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] data, input logic last);
    int unsigned gap;
    gap = no_stalls ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic scan_byte(input logic [wbps_pkg::BYTE_W-1:0] data);
    if (buf_left == 0) buf_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
    buf_left--;
    send_byte(data, buf_left == 0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx,
                           input logic [wbps_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_scan(input logic [wbps_pkg::PAT_W-1:0] pat,
                          input logic [wbps_pkg::MASK_W-1:0] mask,
                          input logic [wbps_pkg::LEN_W-1:0] len, input bit junk);
    logic [63:0] upper;
    upper = junk ? {$urandom, $urandom} : 64'd0;
    cfg_write(wbps_pkg::REG_PATTERN_BYTES, pat);
    cfg_write(wbps_pkg::REG_WILDCARD_MASK, {upper[63:8], mask});
    cfg_write(wbps_pkg::REG_PATTERN_LENGTH, {upper[63:4], len});
  endtask

  initial begin
    logic [wbps_pkg::BYTE_W-1:0] alt_seq [9];
    logic [wbps_pkg::PAT_W-1:0]  pat;
    logic [wbps_pkg::MASK_W-1:0] mask;
    logic [wbps_pkg::LEN_W-1:0]  len;
    int unsigned                 scanned;
    int unsigned                 phases;
    int unsigned                 n;
    int unsigned                 k;
    int unsigned                 sel;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The empty pattern left by reset must never match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // Overlapping occurrences of a two byte pattern.
    set_scan(64'hAAAA, 8'h00, 4'd2, 1'b0);
    for (int i = 0; i < 4; i++) send_byte(8'hAA, i == 3);
    wait_drained();

    // Full-length pattern with wildcards at both ends; no hit before the window fills.
    set_scan(64'h00FF_00FF_00FF_00FF, 8'h81, 4'd8, 1'b0);
    alt_seq = '{8'h3C, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hC3, 8'h00};
    foreach (alt_seq[i]) send_byte(alt_seq[i], i == 8);
    wait_drained();

    // Lengths beyond the window never match, even when every byte is a wildcard.
    set_scan('1, 8'hFF, 4'd9, 1'b1);
    for (int i = 0; i < 3; i++) send_byte(8'hFF, 1'b0);
    wait_drained();
    cfg_write(wbps_pkg::REG_PATTERN_LENGTH, 64'd15);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // Mask bits and pattern bytes above the length are ignored.
    set_scan(64'hDEAD_BEEF_1234_565A, 8'hFE, 4'd1, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_drained();

    // A write to an unmapped register leaves the setup unchanged.
    cfg_write(REG_UNMAPPED, '1);
    send_byte(8'h5A, 1'b1);
    wait_drained();

    scanned = 0;
    phases = 6;
    while (scanned < RANDOM_BYTES) begin
      no_stalls = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: len = 4'd0;
        1: len = 4'($urandom_range(9, 15));
        default: len = 4'($urandom_range(1, 8));
      endcase
      pat = {$urandom, $urandom};
      mask = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom & $urandom);
      set_scan(pat, mask, len, $urandom_range(0, 1));
      n = $urandom_range(40, 120);
      k = 0;
      while (k < n) begin
        if (len >= 1 && len <= SCAN_DEPTH && $urandom_range(0, 2) == 0) begin
          for (int i = 0; i < len; i++) scan_byte(mask[i] ? 8'($urandom) : pat[8*i +: 8]);
          k += len;
        end else begin
          sel = $urandom_range(0, 7);
          scan_byte($urandom_range(0, 1) ? pat[8*sel +: 8] : 8'($urandom));
          k++;
        end
      end
      scanned += k;
      phases++;
      wait_drained();
    end

    no_stalls = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Scanned %0d bytes under %0d pattern setups.", sb.bytes_seen, phases);
    $display("%0d transfers reported a match, %0d ended a buffer; mismatches counted: %0d.",
             sb.hits_seen, sb.buffers_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
